/* src/smau_pkg.sv */
// Package for the small matrix arithmetic unit.
// Holds transaction structs, operation and mode codes and size defaults.
// No dependencies.
package smau_pkg;

  localparam int MaxDim   = 8;
  localparam int FracBits = 16;

  localparam logic [1:0] ModeLoadA = 2'd0;
  localparam logic [1:0] ModeLoadB = 2'd1;
  localparam logic [1:0] ModeStart = 2'd2;

  localparam logic [3:0] OpAdd    = 4'd0;
  localparam logic [3:0] OpSubAB  = 4'd1;
  localparam logic [3:0] OpSubBA  = 4'd2;
  localparam logic [3:0] OpMulAB  = 4'd3;
  localparam logic [3:0] OpMulBA  = 4'd4;
  localparam logic [3:0] OpAddSI  = 4'd5;
  localparam logic [3:0] OpSubSI  = 4'd6;
  localparam logic [3:0] OpScale  = 4'd7;
  localparam logic [3:0] OpDet    = 4'd8;

  localparam logic [1:0] RegDim    = 2'd0;
  localparam logic [1:0] RegOp     = 2'd1;
  localparam logic [1:0] RegScalar = 2'd2;

  typedef struct packed {
    logic [1:0]         mode;
    logic [2:0]         row;
    logic [2:0]         col;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         out_row;
    logic [2:0]         out_col;
    logic signed [31:0] result;
    logic               last;
    logic               error;
  } out_item_t;

endpackage

/* src/small_matrix_arithmetic_unit.sv */
// Small matrix arithmetic unit: top level with stores, sequencer and one
// shared multiply-accumulate unit. Depends on smau_pkg.
//
// Loads of A or B write their store directly; busy stays low. A start runs the
// operation on one shared 32x32 multiplier with a 64-bit accumulator.
// Element-wise operations read, execute and emit each element; A*B and B*A
// take one operand read and one multiply-add per term, then emit. The
// determinant forms three minors then three cofactor terms for size 3, two
// products for size 2, and goes straight to emit for other sizes. Each
// result strobe comes in the cycle after its emit state. busy falls in the
// cycle of the last result strobe, so a new start can be taken in that
// cycle. Results appear once on out with out_valid for one cycle and cannot be stalled.
module small_matrix_arithmetic_unit #(
  parameter int MAX_DIM   = smau_pkg::MaxDim,
  parameter int FRAC_BITS = smau_pkg::FracBits
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  smau_pkg::in_item_t  in_item,
  output logic                busy,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  output logic                out_valid,
  output smau_pkg::out_item_t out
);

  localparam int IW = $clog2(MAX_DIM) < 1 ? 1 : $clog2(MAX_DIM);
  localparam int AW = 2 * IW;
  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int CW = $clog2(MAX_DIM + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RD    = 4'd1;  // issue operand read
  localparam logic [3:0] S_EX    = 4'd2;  // multiply/add with read data
  localparam logic [3:0] S_EMIT  = 4'd3;
  localparam logic [3:0] S_DRD   = 4'd4;  // determinant operand read
  localparam logic [3:0] S_DEX   = 4'd5;
  localparam logic [3:0] S_DEMIT = 4'd6;

  // configuration
  logic [3:0]         dim;
  logic [3:0]         operation;
  logic signed [31:0] scalar;

  always_ff @(posedge clk) begin
    if (rst) begin
      dim       <= 4'd1;
      operation <= smau_pkg::OpAdd;
      scalar    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        smau_pkg::RegDim:    dim       <= cfg_data[3:0];
        smau_pkg::RegOp:     operation <= cfg_data[3:0];
        smau_pkg::RegScalar: scalar    <= cfg_data;
        default: ;
      endcase
    end
  end

  // stores
  logic signed [31:0] mem_a [DEPTH];
  logic signed [31:0] mem_b [DEPTH];
  logic [AW-1:0]      ra, rb;
  logic signed [31:0] da, db;

  logic [3:0] state;
  logic       accept;
  logic       ld_ok;
  assign busy   = state != S_IDLE;
  assign accept = start && !busy;
  assign ld_ok  = (32'(in_item.row) < MAX_DIM) && (32'(in_item.col) < MAX_DIM);

  always_ff @(posedge clk) begin
    if (accept && ld_ok && in_item.mode == smau_pkg::ModeLoadA)
      mem_a[AW'(in_item.row) * AW'(MAX_DIM) + AW'(in_item.col)] <= in_item.value;
    if (accept && ld_ok && in_item.mode == smau_pkg::ModeLoadB)
      mem_b[AW'(in_item.row) * AW'(MAX_DIM) + AW'(in_item.col)] <= in_item.value;
    da <= mem_a[ra];
    db <= mem_b[rb];
  end

  // sequencer registers
  logic [3:0]         op;
  logic [CW-1:0]      n;
  logic [IW-1:0]      i, j, k;
  logic [4:0]         step;
  logic signed [63:0] acc;
  logic signed [31:0] m0, m1, m2;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // shared unit: floored product of two words
  logic signed [31:0] mul_x, mul_y;
  logic signed [63:0] prod, fprod;
  assign prod  = mul_x * mul_y;
  assign fprod = prod >>> FRAC_BITS;

  // element address of (r,c)
  function automatic logic [AW-1:0] addr(input logic [IW-1:0] r, input logic [IW-1:0] c);
    return AW'(r) * AW'(MAX_DIM) + AW'(c);
  endfunction

  // determinant schedule: step -> operand addresses (all in A)
  logic [IW-1:0] dr0, dc0, dr1, dc1;
  logic          dsub;
  always_comb begin
    dr0 = '0; dc0 = '0; dr1 = '0; dc1 = '0; dsub = 1'b0;
    unique case (step)
      // size 2: a00*a11 - a10*a01
      5'd0: begin dr0 = IW'(0); dc0 = IW'(0); dr1 = IW'(1); dc1 = IW'(1); end
      5'd1: begin dr0 = IW'(1); dc0 = IW'(0); dr1 = IW'(0); dc1 = IW'(1); dsub = 1'b1; end
      // size 3 minors
      5'd2: begin dr0 = IW'(1); dc0 = IW'(1); dr1 = IW'(2); dc1 = IW'(2); end
      5'd3: begin dr0 = IW'(1); dc0 = IW'(2); dr1 = IW'(2); dc1 = IW'(1); dsub = 1'b1; end
      5'd4: begin dr0 = IW'(1); dc0 = IW'(0); dr1 = IW'(2); dc1 = IW'(2); end
      5'd5: begin dr0 = IW'(1); dc0 = IW'(2); dr1 = IW'(2); dc1 = IW'(0); dsub = 1'b1; end
      5'd6: begin dr0 = IW'(1); dc0 = IW'(0); dr1 = IW'(2); dc1 = IW'(1); end
      5'd7: begin dr0 = IW'(1); dc0 = IW'(1); dr1 = IW'(2); dc1 = IW'(0); dsub = 1'b1; end
      // cofactor terms: a0x times minor
      5'd8:  begin dr0 = IW'(0); dc0 = IW'(0); end
      5'd9:  begin dr0 = IW'(0); dc0 = IW'(1); dsub = 1'b1; end
      5'd10: begin dr0 = IW'(0); dc0 = IW'(2); end
      default: ;
    endcase
  end

  logic [IW-1:0] nm1;
  logic          is_mul;
  logic          diag;
  assign nm1    = IW'(n - CW'(1));
  assign is_mul = (op == smau_pkg::OpMulAB) || (op == smau_pkg::OpMulBA);
  assign diag   = i == j;

  // determinant second operand is read through a second read port of store A
  logic signed [31:0] da2;
  logic [AW-1:0]      ra2;
  always_ff @(posedge clk) da2 <= mem_a[ra2];

  // operand selection for the shared unit
  logic signed [31:0] minor_sel;
  always_comb begin
    unique case (step)
      5'd8:    minor_sel = m0;
      5'd9:    minor_sel = m1;
      default: minor_sel = m2;
    endcase
    mul_x = da;
    mul_y = db;
    if (state == S_DEX) begin
      mul_y = (step >= 5'd8) ? minor_sel : da2;
    end else if (op == smau_pkg::OpScale) begin
      mul_y = scalar;
    end else if (op == smau_pkg::OpMulBA) begin
      mul_x = db;
      mul_y = da;
    end
  end

  always_comb begin
    ra = addr(i, j);
    rb = addr(i, j);
    ra2 = addr(dr1, dc1);
    if (state == S_DRD || state == S_DEX) begin
      ra = addr(dr0, dc0);
    end else if (is_mul) begin
      if (op == smau_pkg::OpMulAB) begin
        ra = addr(i, k); rb = addr(k, j);
      end else begin
        rb = addr(i, k); ra = addr(k, j);
      end
    end
  end

  logic signed [31:0] elem;
  always_comb begin
    unique case (op)
      smau_pkg::OpAdd:   elem = sat32(66'(da) + 66'(db));
      smau_pkg::OpSubAB: elem = sat32(66'(da) - 66'(db));
      smau_pkg::OpSubBA: elem = sat32(66'(db) - 66'(da));
      smau_pkg::OpAddSI: elem = diag ? sat32(66'(da) + 66'(scalar)) : da;
      smau_pkg::OpSubSI: elem = diag ? sat32(66'(da) - 66'(scalar)) : da;
      smau_pkg::OpScale: elem = sat32(66'(fprod));
      default:           elem = sat32(66'(acc));
    endcase
  end

  logic signed [31:0] res_q;
  logic [2:0]         orow, ocol;
  logic               olast, oerr;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept && in_item.mode == smau_pkg::ModeStart &&
              operation <= smau_pkg::OpDet) begin
            op  <= operation;
            n   <= (dim == 4'd0) ? CW'(1) :
                   (32'(dim) > MAX_DIM) ? CW'(MAX_DIM) : CW'(dim);
            i   <= '0; j <= '0; k <= '0; acc <= '0;
            if (operation == smau_pkg::OpDet) begin
              // sizes 1 and 2 start at a00, size 3 at the first minor
              step  <= (dim <= 4'd2) ? 5'd0 : 5'd2;
              state <= S_DRD;
            end else begin
              state <= S_RD;
            end
          end
        end
        S_RD: state <= S_EX;
        S_EX: begin
          if (is_mul) begin
            acc <= acc + fprod;
            if (k == nm1) state <= S_EMIT;
            else begin
              k <= k + IW'(1);
              state <= S_RD;
            end
          end else begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          out_valid <= 1'b1;
          orow  <= 3'(i);
          ocol  <= 3'(j);
          res_q <= elem;
          oerr  <= 1'b0;
          olast <= (i == nm1) && (j == nm1);
          acc   <= '0;
          k     <= '0;
          if (i == nm1 && j == nm1) state <= S_IDLE;
          else begin
            state <= S_RD;
            if (j == nm1) begin
              j <= '0;
              i <= i + IW'(1);
            end else j <= j + IW'(1);
          end
        end
        S_DRD: begin
          if (n > CW'(3) || n == CW'(1)) state <= S_DEMIT;
          else state <= S_DEX;
        end
        S_DEX: begin
          step <= step + 5'd1;
          if (step == 5'd1 || step == 5'd10) begin
            acc   <= dsub ? acc - fprod : acc + fprod;
            state <= S_DEMIT;
          end else if (step == 5'd3 || step == 5'd5 || step == 5'd7) begin
            // close a minor and clear for the next
            acc   <= '0;
            state <= S_DRD;
            if (step == 5'd3) m0 <= sat32(66'(acc - fprod));
            if (step == 5'd5) m1 <= sat32(66'(acc - fprod));
            if (step == 5'd7) m2 <= sat32(66'(acc - fprod));
          end else begin
            acc   <= dsub ? acc - fprod : acc + fprod;
            state <= S_DRD;
          end
        end
        S_DEMIT: begin
          out_valid <= 1'b1;
          orow  <= '0;
          ocol  <= '0;
          olast <= 1'b1;
          oerr  <= n > CW'(3);
          if (n > CW'(3)) res_q <= '0;
          else if (n == CW'(1)) res_q <= da;
          else res_q <= sat32(66'(acc));
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out.out_row = orow;
  assign out.out_col = ocol;
  assign out.result  = res_q;
  assign out.last    = olast;
  assign out.error   = oerr;

  // no start accepted while a run is in flight
  a_busy_blocks: assert property (@(posedge clk) disable iff (rst)
    busy |-> !accept) else $error("accept while busy");
  // a strobe marked last ends the run
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out.last) |-> !busy) else $error("busy after last");
  // error only on a single determinant result
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out.error) |-> (out.last && out.result == 32'sd0))
    else $error("error flag on bad result");
  // results come only during a run
  a_strobe_run: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $past(busy)) else $error("strobe outside run");

endmodule

/* tb/small_matrix_arithmetic_unit_test.sv */
// Testbench for the small matrix arithmetic unit: loads, starts and
// configuration writes checked against an in-bench predictor.
// Depends on smau_pkg and small_matrix_arithmetic_unit.
`timescale 1ns / 1ps

class matrix_scoreboard;
  logic signed [31:0] mat_a [smau_pkg::MaxDim*smau_pkg::MaxDim];
  logic signed [31:0] mat_b [smau_pkg::MaxDim*smau_pkg::MaxDim];
  logic [3:0] size_reg;
  logic [3:0] op_reg;
  logic signed [31:0] scalar_reg;
  smau_pkg::out_item_t pending [$];
  int errors;
  int results_seen;

  function new();
    size_reg = 4'd1;
    op_reg = smau_pkg::OpAdd;
    scalar_reg = 0;
    errors = 0;
    results_seen = 0;
    foreach (mat_a[i]) begin
      mat_a[i] = 0;
      mat_b[i] = 0;
    end
  endfunction

  function void write_reg(logic [1:0] idx, logic [31:0] data);
    if (idx == smau_pkg::RegDim) size_reg = data[3:0];
    else if (idx == smau_pkg::RegOp) op_reg = data[3:0];
    else if (idx == smau_pkg::RegScalar) scalar_reg = data;
  endfunction

  // Floored Q16.16 product
  function longint fx_mul(logic signed [31:0] a, logic signed [31:0] b);
    longint p;
    p = longint'(a) * longint'(b);
    return p >>> smau_pkg::FracBits;
  endfunction

  function logic signed [31:0] clamp(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function logic signed [31:0] determinant(int n);
    logic signed [31:0] m0, m1, m2;
    int md;
    md = smau_pkg::MaxDim;
    if (n == 1) return mat_a[0];
    if (n == 2) return clamp(fx_mul(mat_a[0], mat_a[md+1]) -
                             fx_mul(mat_a[md], mat_a[1]));
    m0 = clamp(fx_mul(mat_a[md+1], mat_a[2*md+2]) -
               fx_mul(mat_a[md+2], mat_a[2*md+1]));
    m1 = clamp(fx_mul(mat_a[md], mat_a[2*md+2]) -
               fx_mul(mat_a[md+2], mat_a[2*md]));
    m2 = clamp(fx_mul(mat_a[md], mat_a[2*md+1]) -
               fx_mul(mat_a[md+1], mat_a[2*md]));
    return clamp(fx_mul(mat_a[0], m0) - fx_mul(mat_a[1], m1) + fx_mul(mat_a[2], m2));
  endfunction

  function logic signed [31:0] cell_value(int n, int i, int j);
    longint av, bv, acc;
    int md;
    md = smau_pkg::MaxDim;
    av = mat_a[i*md+j];
    bv = mat_b[i*md+j];
    acc = 0;
    case (op_reg)
      smau_pkg::OpAdd:   return clamp(av + bv);
      smau_pkg::OpSubAB: return clamp(av - bv);
      smau_pkg::OpSubBA: return clamp(bv - av);
      smau_pkg::OpMulAB: begin
        for (int k = 0; k < n; k++)
          acc += fx_mul(mat_a[i*md+k], mat_b[k*md+j]);
        return clamp(acc);
      end
      smau_pkg::OpMulBA: begin
        for (int k = 0; k < n; k++)
          acc += fx_mul(mat_b[i*md+k], mat_a[k*md+j]);
        return clamp(acc);
      end
      smau_pkg::OpAddSI: return (i == j) ? clamp(av + longint'(scalar_reg)) : av[31:0];
      smau_pkg::OpSubSI: return (i == j) ? clamp(av - longint'(scalar_reg)) : av[31:0];
      default: return clamp(fx_mul(av[31:0], scalar_reg));
    endcase
  endfunction

  // Note an accepted input transaction and queue its expected results
  function void note_input(smau_pkg::in_item_t it);
    int n;
    smau_pkg::out_item_t e;
    if (it.mode == smau_pkg::ModeLoadA) begin
      mat_a[it.row*smau_pkg::MaxDim+it.col] = it.value;
      return;
    end
    if (it.mode == smau_pkg::ModeLoadB) begin
      mat_b[it.row*smau_pkg::MaxDim+it.col] = it.value;
      return;
    end
    if (it.mode != smau_pkg::ModeStart || op_reg > smau_pkg::OpDet) return;
    n = size_reg;
    if (n < 1) n = 1;
    if (n > smau_pkg::MaxDim) n = smau_pkg::MaxDim;
    if (op_reg == smau_pkg::OpDet) begin
      e = '0;
      e.last = 1'b1;
      if (n > 3) e.error = 1'b1;
      else e.result = determinant(n);
      pending.push_back(e);
      return;
    end
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++) begin
        e.out_row = 3'(i);
        e.out_col = 3'(j);
        e.result = cell_value(n, i, j);
        e.last = (i == n-1) && (j == n-1);
        e.error = 1'b0;
        pending.push_back(e);
      end
  endfunction

  function void check_result(smau_pkg::out_item_t got);
    smau_pkg::out_item_t e;
    results_seen++;
    if (pending.size() == 0) begin
      $error("result with nothing expected: %p", got);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (got.out_row !== e.out_row) begin
      $error("out_row expected %0d actual %0d", e.out_row, got.out_row); errors++;
    end
    if (got.out_col !== e.out_col) begin
      $error("out_col expected %0d actual %0d", e.out_col, got.out_col); errors++;
    end
    if (got.result !== e.result) begin
      $error("result expected %h actual %h", e.result, got.result); errors++;
    end
    if (got.last !== e.last) begin
      $error("last expected %b actual %b", e.last, got.last); errors++;
    end
    if (got.error !== e.error) begin
      $error("error expected %b actual %b", e.error, got.error); errors++;
    end
  endfunction
endclass

module small_matrix_arithmetic_unit_test;
  localparam int StallLimit = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  smau_pkg::in_item_t in_item = '0;
  logic busy;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = smau_pkg::RegDim;
  logic [31:0] cfg_data = '0;
  logic out_valid;
  smau_pkg::out_item_t out;

  matrix_scoreboard board;
  int idle_cycles = 0;
  int starts_sent = 0;

  small_matrix_arithmetic_unit dut (
    .clk(clk), .rst(rst), .start(start), .in_item(in_item), .busy(busy),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_valid(out_valid), .out(out)
  );

  always #1 clk = ~clk;

  // Check results and watch for a stalled block
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid) board.check_result(out);
      if (out_valid || (start && !busy) || cfg_we) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > StallLimit) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  function automatic int gap_len();
    if ($urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(0, 32'h3ffff) - 32'h20000;
      default: return $urandom();
    endcase
  endfunction

  // Drive one transaction and hold it until accepted; start stays high
  // into the next transaction when there is no gap
  task automatic send_item(logic [1:0] mode, logic [2:0] r, logic [2:0] c,
                           logic [31:0] v);
    smau_pkg::in_item_t it;
    int gap;
    it.mode = mode; it.row = r; it.col = c; it.value = v;
    start <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_input(it);
    if (mode == smau_pkg::ModeStart) starts_sent++;
    gap = gap_len();
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop start, let the block drain, then allow for a trailing silent pass
  task automatic drain();
    start <= 1'b0;
    while (board.pending.size() != 0 || busy) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [31:0] data);
    drain();
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= data;
    @(posedge clk);
    board.write_reg(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic fill_all(bit extreme);
    for (int r = 0; r < smau_pkg::MaxDim; r++)
      for (int c = 0; c < smau_pkg::MaxDim; c++) begin
        send_item(smau_pkg::ModeLoadA, 3'(r), 3'(c),
                  extreme ? 32'h7fffffff : rand_word());
        send_item(smau_pkg::ModeLoadB, 3'(r), 3'(c),
                  extreme ? 32'h80000000 : rand_word());
      end
  endtask

  task automatic run_op(logic [3:0] op, logic [3:0] n);
    write_cfg(smau_pkg::RegOp, 32'(op));
    write_cfg(smau_pkg::RegDim, 32'(n));
    send_item(smau_pkg::ModeStart, 3'($urandom()), 3'($urandom()), $urandom());
  endtask

  initial begin
    board = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes in every element, every operation
    fill_all(1'b1);
    write_cfg(smau_pkg::RegScalar, 32'h80000000);
    for (int op = 0; op <= 8; op++)
      run_op(4'(op), (4'(op) == smau_pkg::OpDet) ? 4'd3 : 4'd8);
    write_cfg(smau_pkg::RegScalar, 32'h7fffffff);
    run_op(smau_pkg::OpAddSI, 4'd2);
    run_op(smau_pkg::OpScale, 4'd1);
    run_op(smau_pkg::OpDet, 4'd1);
    run_op(smau_pkg::OpDet, 4'd2);
    run_op(smau_pkg::OpDet, 4'd4);
    run_op(smau_pkg::OpAdd, 4'd0);
    run_op(smau_pkg::OpAdd, 4'd15);
    run_op(4'd9, 4'd2);
    run_op(4'd15, 4'd2);
    send_item(2'd3, 3'd7, 3'd7, 32'hffffffff);

    // Random: reloads with random content and starts under random settings
    fill_all(1'b0);
    for (int b = 0; b < 22; b++) begin
      if (b == 20) drain();
      if ($urandom_range(0, 3) == 0) write_cfg(smau_pkg::RegScalar, rand_word());
      if ($urandom_range(0, 2) == 0)
        write_cfg(smau_pkg::RegOp, ($urandom_range(0, 9) == 0) ?
                  $urandom_range(9, 15) : $urandom_range(0, 8));
      if ($urandom_range(0, 2) == 0)
        write_cfg(smau_pkg::RegDim, ($urandom_range(0, 9) == 0) ? $urandom_range(9, 15) :
                  (($urandom_range(0, 3) == 0) ? $urandom_range(4, 8) : $urandom_range(0, 3)));
      for (int k = 0; k < 10; k++)
        send_item(($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 1)),
                  3'($urandom()), 3'($urandom()), rand_word());
      send_item(smau_pkg::ModeStart, 3'($urandom()), 3'($urandom()), $urandom());
    end

    drain();
    $display("covered %0d starts and %0d results over all operations and sizes",
             starts_sent, board.results_seen);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
